[sv/bounding_box_accumulator_3d_core_defines.svh]
// assertion macros shared by the bounding box accumulator rtl
// depends on nothing; define NO_ASSERTIONS to compile the checks out
`ifndef BOUNDING_BOX_ACCUMULATOR_3D_CORE_DEFINES_SVH
`define BOUNDING_BOX_ACCUMULATOR_3D_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// clocked check, masked while reset is held
`define BBA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bba3d assertion failed");
// clocked check with no reset masking
`define BBA_ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bba3d assertion failed");
`else
`define BBA_ASSERT(lbl, clk, rst_n, prop)
`define BBA_ASSERT_CLK(lbl, clk, prop)
`endif
`endif

[sv/bba3d_pkg.sv]
// shared types and constants of the 3d bounding box accumulator
// used by every module of the block; depends on nothing
package bba3d_pkg;

    localparam int COORD_BITS_DEF = 16;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXT,
        ST_MXY,
        ST_MYZ,
        ST_MZX,
        ST_MVL,
        ST_MVH,
        ST_FIN
    } seq_state_t;

    // operand pairs of the shared multiplier
    typedef enum logic [2:0] {
        MS_XY,
        MS_YZ,
        MS_ZX,
        MS_VL,
        MS_VH
    } mul_sel_t;

    // accumulator operations
    typedef enum logic [1:0] {
        AO_HOLD,
        AO_LOAD,
        AO_ADD
    } acc_op_t;

    // control word from the sequencer to the datapath
    typedef struct packed {
        logic     s_ready;
        logic     ext_en;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     exy_en;
        acc_op_t  surf_op;
        acc_op_t  vol_op;
        logic     out_load;
    } seq_ctl_t;

endpackage

[sv/bba3d_bounds.sv]
// running min/max bounds of the accumulated box, one lane per axis
// depends on bba3d_pkg
module bba3d_bounds #(
    parameter int COORD_BITS = bba3d_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         take,
    input  logic                         start_new,
    input  logic signed [COORD_BITS-1:0] in_lo  [3],
    input  logic signed [COORD_BITS-1:0] in_hi  [3],
    output logic signed [COORD_BITS-1:0] box_lo [3],
    output logic signed [COORD_BITS-1:0] box_hi [3]
);
    import bba3d_pkg::*;

    localparam logic signed [COORD_BITS-1:0] MOST_POS = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] MOST_NEG = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic signed [COORD_BITS-1:0] lo_reg  [3];
    logic signed [COORD_BITS-1:0] hi_reg  [3];
    logic signed [COORD_BITS-1:0] lo_next [3];
    logic signed [COORD_BITS-1:0] hi_next [3];

    // load or merge, axes are independent
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lo_next[i] = lo_reg[i];
            hi_next[i] = hi_reg[i];
            if (take) begin
                if (start_new) begin
                    lo_next[i] = in_lo[i];
                    hi_next[i] = in_hi[i];
                end else begin
                    lo_next[i] = (in_lo[i] < lo_reg[i]) ? in_lo[i] : lo_reg[i];
                    hi_next[i] = (in_hi[i] > hi_reg[i]) ? in_hi[i] : hi_reg[i];
                end
            end
        end
    end

    // bounds start out empty
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            if (!aresetn) begin
                lo_reg[i] <= MOST_POS;
                hi_reg[i] <= MOST_NEG;
            end else begin
                lo_reg[i] <= lo_next[i];
                hi_reg[i] <= hi_next[i];
            end
        end
    end

    assign box_lo = lo_reg;
    assign box_hi = hi_reg;

endmodule

[sv/bba3d_mul.sv]
// shared unsigned multiplier with a registered product
// depends on bba3d_pkg
module bba3d_mul #(
    parameter int OP_W = bba3d_pkg::COORD_BITS_DEF + 1
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [OP_W-1:0]   op_a,
    input  logic [OP_W-1:0]   op_b,
    output logic [2*OP_W-1:0] prod
);
    import bba3d_pkg::*;

    logic [2*OP_W-1:0] prod_reg;

    // product holds while the unit is not stepped
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

[sv/bba3d_ctrl.sv]
// sequencer: steps the shared multiplier through the five products
// depends on bba3d_pkg and the assertion macro header
`include "bounding_box_accumulator_3d_core_defines.svh"
module bba3d_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                in_last,
    input  logic                out_free,
    output bba3d_pkg::seq_ctl_t ctl
);
    import bba3d_pkg::*;

    seq_state_t state_reg;
    seq_state_t state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && in_last) begin
                    state_next = ST_EXT;
                end
            end
            ST_EXT:  state_next = ST_MXY;
            ST_MXY:  state_next = ST_MYZ;
            ST_MYZ:  state_next = ST_MZX;
            ST_MZX:  state_next = ST_MVL;
            ST_MVL:  state_next = ST_MVH;
            ST_MVH:  state_next = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // control word per state
    always_comb begin
        ctl          = '0;
        ctl.mul_sel  = MS_XY;
        ctl.surf_op  = AO_HOLD;
        ctl.vol_op   = AO_HOLD;
        unique case (state_reg)
            ST_IDLE: ctl.s_ready = 1'b1;
            ST_EXT:  ctl.ext_en  = 1'b1;
            ST_MXY: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_XY;
            end
            ST_MYZ: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_YZ;
                ctl.exy_en  = 1'b1;
                ctl.surf_op = AO_LOAD;
            end
            ST_MZX: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_ZX;
                ctl.surf_op = AO_ADD;
            end
            ST_MVL: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_VL;
                ctl.surf_op = AO_ADD;
            end
            ST_MVH: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_VH;
                ctl.vol_op  = AO_LOAD;
            end
            ST_FIN:  ctl.out_load = out_free;
            default: ctl.s_ready  = 1'b0;
        endcase
    end

    // a last beat starts the measurement run
    `BBA_ASSERT(a_last_starts_run, aclk, aresetn, (aresetn && ctl.s_ready && s_valid && in_last) |=> (state_reg == ST_EXT))
    // a plain beat keeps the block open for the next one
    `BBA_ASSERT(a_plain_stays_idle, aclk, aresetn, (aresetn && ctl.s_ready && s_valid && !in_last) |=> (state_reg == ST_IDLE))
    // a finished result waits while the output register is still full
    `BBA_ASSERT(a_fin_waits, aclk, aresetn, (aresetn && state_reg == ST_FIN && !out_free) |=> (state_reg == ST_FIN))
    // the volume high part is taken right after its product
    `BBA_ASSERT(a_mvh_then_fin, aclk, aresetn, (aresetn && state_reg == ST_MVH) |=> (state_reg == ST_FIN && !ctl.mul_en))

endmodule

[sv/bounding_box_accumulator_3d_core.sv]
// top level of the 3d axis-aligned bounding box accumulator
// depends on bba3d_pkg, bba3d_bounds, bba3d_mul and bba3d_ctrl
//
// Usage:
//   s_axis carries one box per beat: tdata holds lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
//   (signed Q8.8), tuser is start_new (load instead of merge), tlast is last_item.
//   A point is sent with lo equal to hi.
//   m_axis carries one result per tlast beat: the held bounds, the volume (Q27.24),
//   the surface (Q21.16) and the largest extent (Q9.8).
//   A beat without tlast is merged and s_axis_tready stays high for the next.
//   A tlast beat is merged in its accept cycle, then s_axis_tready stays low while the
//   sequencer computes the extents, runs five products on the one shared multiplier
//   (ex*ey, ey*ez, ez*ex, then the volume in two halves) and loads the result.
//   m_axis_tvalid rises once the result register has been loaded.
//   The result sits in an output register; when the receiver stalls, new beats are
//   still taken, and only the next tlast result waits in its last step until the
//   register is free.
//   Reset (aresetn low, synchronous) empties the bounds (low most positive, high most
//   negative), drops m_axis_tvalid and returns the sequencer to idle.
`include "bounding_box_accumulator_3d_core_defines.svh"
module bounding_box_accumulator_3d_core #(
    parameter int  COORD_BITS  = bba3d_pkg::COORD_BITS_DEF,
    localparam int EXT_W       = COORD_BITS + 1,
    localparam int VOL_W       = 3 * EXT_W,
    localparam int SURF_W      = 2 * EXT_W + 3,
    localparam int IN_TDATA_W  = ((6 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((6 * COORD_BITS + VOL_W + SURF_W + EXT_W + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z from bit 0 up
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // start_new
    input  logic                   s_axis_tuser,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z,
    // box_volume, box_surface, largest_extent from bit 0 up, zero padded
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);
    import bba3d_pkg::*;

    localparam int PROD_W = 2 * EXT_W;
    localparam int SACC_W = PROD_W + 2;

    seq_ctl_t ctl;
    logic     accept;
    logic     out_free;

    logic signed [COORD_BITS-1:0] in_lo  [3];
    logic signed [COORD_BITS-1:0] in_hi  [3];
    logic signed [COORD_BITS-1:0] box_lo [3];
    logic signed [COORD_BITS-1:0] box_hi [3];

    logic signed [EXT_W-1:0] diff     [3];
    logic        [EXT_W-1:0] ext_reg  [3];
    logic        [EXT_W-1:0] ext_next [3];

    logic [EXT_W-1:0]  mul_a;
    logic [EXT_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] exy_reg;
    logic [SACC_W-1:0] surf_acc_reg;
    logic [SACC_W-1:0] surf_acc_next;
    logic [VOL_W-1:0]  vol_acc_reg;
    logic [VOL_W-1:0]  vol_acc_next;
    logic [VOL_W-1:0]  vol_final;
    logic [EXT_W-1:0]  largest;

    logic signed [COORD_BITS-1:0] out_lo_reg [3];
    logic signed [COORD_BITS-1:0] out_hi_reg [3];
    logic [VOL_W-1:0]             out_vol_reg;
    logic [SURF_W-1:0]            out_surf_reg;
    logic [EXT_W-1:0]             out_ext_reg;
    logic                         m_valid_reg;
    logic                         m_valid_next;

    // unpack the input beat
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_lo[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
            in_hi[i] = s_axis_tdata[(i+3)*COORD_BITS +: COORD_BITS];
        end
    end

    assign s_axis_tready = ctl.s_ready;
    assign accept        = s_axis_tvalid && ctl.s_ready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    bba3d_bounds #(
        .COORD_BITS (COORD_BITS)
    ) u_bounds (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (accept),
        .start_new (s_axis_tuser),
        .in_lo     (in_lo),
        .in_hi     (in_hi),
        .box_lo    (box_lo),
        .box_hi    (box_hi)
    );

    bba3d_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .out_free (out_free),
        .ctl      (ctl)
    );

    // per-axis extent, an inverted axis counts as zero
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = {box_hi[i][COORD_BITS-1], box_hi[i]}
                    - {box_lo[i][COORD_BITS-1], box_lo[i]};
            ext_next[i] = diff[i][EXT_W-1] ? '0 : diff[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ext_en) begin
            ext_reg <= ext_next;
        end
    end

    // operand pair for the shared multiplier
    always_comb begin
        unique case (ctl.mul_sel)
            MS_XY: begin
                mul_a = ext_reg[0];
                mul_b = ext_reg[1];
            end
            MS_YZ: begin
                mul_a = ext_reg[1];
                mul_b = ext_reg[2];
            end
            MS_ZX: begin
                mul_a = ext_reg[2];
                mul_b = ext_reg[0];
            end
            MS_VL: begin
                mul_a = exy_reg[EXT_W-1:0];
                mul_b = ext_reg[2];
            end
            MS_VH: begin
                mul_a = exy_reg[PROD_W-1:EXT_W];
                mul_b = ext_reg[2];
            end
            default: begin
                mul_a = ext_reg[0];
                mul_b = ext_reg[1];
            end
        endcase
    end

    bba3d_mul #(
        .OP_W (EXT_W)
    ) u_mul (
        .aclk (aclk),
        .en   (ctl.mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // face product sum and volume low half
    always_comb begin
        unique case (ctl.surf_op)
            AO_HOLD: surf_acc_next = surf_acc_reg;
            AO_LOAD: surf_acc_next = SACC_W'(prod);
            AO_ADD:  surf_acc_next = surf_acc_reg + SACC_W'(prod);
            default: surf_acc_next = surf_acc_reg;
        endcase
        unique case (ctl.vol_op)
            AO_HOLD: vol_acc_next = vol_acc_reg;
            AO_LOAD: vol_acc_next = VOL_W'(prod);
            AO_ADD:  vol_acc_next = vol_acc_reg + VOL_W'(prod);
            default: vol_acc_next = vol_acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.exy_en) begin
            exy_reg <= prod;
        end
        surf_acc_reg <= surf_acc_next;
        vol_acc_reg  <= vol_acc_next;
    end

    // volume high half and largest extent, taken as the result loads
    assign vol_final = vol_acc_reg + (VOL_W'(prod) << EXT_W);

    always_comb begin
        largest = ext_reg[0];
        if (largest < ext_reg[1]) begin
            largest = ext_reg[1];
        end
        if (largest < ext_reg[2]) begin
            largest = ext_reg[2];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            out_lo_reg   <= box_lo;
            out_hi_reg   <= box_hi;
            out_vol_reg  <= vol_final;
            out_surf_reg <= {surf_acc_reg, 1'b0};
            out_ext_reg  <= largest;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctl.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_ext_reg, out_surf_reg, out_vol_reg,
                                         out_hi_reg[2], out_hi_reg[1], out_hi_reg[0],
                                         out_lo_reg[2], out_lo_reg[1], out_lo_reg[0]});

endmodule
